### design/perspective_triangle_rasterizer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the perspective triangle rasterizer
// Shared forms for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_TRIANGLE_RASTERIZER_CORE_ASSERT_SVH
`define PERSPECTIVE_TRIANGLE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTR_CHECK(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTR_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ptr_pkg.sv
// ----------------------------------------------------------------------------
// ptr_pkg
// Types and constants shared by the rasterizer front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ptr_pkg;

	// Projected coordinates: magnitudes stay below 2**25 for a SCREEN_SIZE up to 1024.
	localparam int COORD_W = 27;
	localparam int COUNT_W = 19;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;

	localparam logic [1:0] FUNC_DRAW  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Job kinds double as the result status codes.
	typedef enum logic [1:0] {
		CMD_DRAW   = 2'd0,
		CMD_REJECT = 2'd1,
		CMD_READ   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		coord_t [2:0] pr;
		coord_t [2:0] pc;
		logic [8:0]  row;
		logic [2:0]  word;
	} job_t;

	typedef struct packed {
		logic               init;
		logic               done;
		cmd_kind_t          status;
		logic [COUNT_W-1:0] count;
		logic [63:0]        data;
	} bk_stat_t;

	typedef enum logic [2:0] {
		FE_IDLE,
		FE_LOAD,
		FE_DIV,
		FE_FIN,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [3:0] {
		BK_INIT,
		BK_IDLE,
		BK_CLEAR,
		BK_READ,
		BK_READ_WAIT,
		BK_BOX,
		BK_SETUP,
		BK_ROW,
		BK_RD,
		BK_PIX,
		BK_WR,
		BK_MARK_RD,
		BK_MARK_WR
	} bk_state_t;

endpackage

`default_nettype wire

### design/ptr_front.sv
// ----------------------------------------------------------------------------
// ptr_front
// Takes commands, rejects triangles behind the eye and projects the vertices
// with a restoring divider, then queues a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_front #(
	parameter int SCREEN_SIZE = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          func,
	input  logic signed [15:0]  v0_x,
	input  logic signed [15:0]  v0_y,
	input  logic signed [15:0]  v0_z,
	input  logic signed [15:0]  v1_x,
	input  logic signed [15:0]  v1_y,
	input  logic signed [15:0]  v1_z,
	input  logic signed [15:0]  v2_x,
	input  logic signed [15:0]  v2_y,
	input  logic signed [15:0]  v2_z,
	input  logic [8:0]          read_row,
	input  logic [2:0]          read_word,
	input  logic                fifo_full,
	output logic                push,
	output ptr_pkg::job_t       job,
	output logic                fe_busy
);
	import ptr_pkg::*;

	localparam int MAG_W = COORD_W - 1;

	fe_state_t state_q, state_d;
	logic signed [15:0] vx_q [3];
	logic signed [15:0] vy_q [3];
	logic signed [15:0] vz_q [3];
	logic [2:0]       job_q;
	logic             neg_q;
	logic [15:0]      den_q;
	logic [15:0]      rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [4:0]       bit_q;
	coord_t           pr_q [3];
	coord_t           pc_q [3];
	cmd_kind_t        imm_kind;

	logic                reject;
	logic [1:0]          vk;
	logic signed [15:0]  sel_x, sel_lat;
	logic signed [16:0]  sum;
	logic signed [27:0]  num, num_abs;
	logic [16:0]         trial, diff;
	logic                ge;
	logic [COORD_W-1:0]  q_up;
	coord_t              coord;

	assign reject = (v0_x <= 16'sd0) || (v1_x <= 16'sd0) || (v2_x <= 16'sd0);
	assign vk = job_q[2:1];
	assign sel_x = vx_q[vk];
	assign sel_lat = job_q[0] ? vz_q[vk] : vy_q[vk];
	assign sum = 17'(sel_x) + 17'(sel_lat);
	assign num = 28'(sum) * 28'(SCREEN_SIZE);
	assign num_abs = num[27] ? -num : num;
	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};
	// Floor division: a negative quotient with a remainder rounds one further down.
	assign q_up = {1'b0, quo_q} + COORD_W'(rem_q != 16'd0);
	assign coord = neg_q ? -$signed(q_up) : $signed({1'b0, quo_q});
	assign fe_busy = (state_q != FE_IDLE);

	always_comb begin
		if (func == FUNC_DRAW)
			imm_kind = CMD_REJECT;
		else if (func == FUNC_CLEAR)
			imm_kind = CMD_CLEAR;
		else
			imm_kind = CMD_READ;
	end

	always_comb begin
		state_d = state_q;
		push = 1'b0;
		job.kind = imm_kind;
		job.row = read_row;
		job.word = read_word;
		for (int i = 0; i < 3; i++) begin
			job.pr[i] = pr_q[i];
			job.pc[i] = pc_q[i];
		end
		unique case (state_q)
			FE_IDLE: begin
				if (accept) begin
					if (func == FUNC_DRAW && !reject)
						state_d = FE_LOAD;
					else
						push = 1'b1;
				end
			end
			FE_LOAD: state_d = FE_DIV;
			FE_DIV: begin
				if (bit_q == 5'(MAG_W - 1))
					state_d = FE_FIN;
			end
			FE_FIN: state_d = (job_q == 3'd5) ? FE_PUSH : FE_LOAD;
			FE_PUSH: begin
				job.kind = CMD_DRAW;
				if (!fifo_full) begin
					push = 1'b1;
					state_d = FE_IDLE;
				end
			end
			default: state_d = FE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			job_q <= '0;
			bit_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FE_IDLE)
				job_q <= '0;
			else if (state_q == FE_FIN)
				job_q <= job_q + 3'd1;
			if (state_q == FE_DIV)
				bit_q <= bit_q + 5'd1;
			else
				bit_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FE_IDLE && accept) begin
			vx_q[0] <= v0_x; vy_q[0] <= v0_y; vz_q[0] <= v0_z;
			vx_q[1] <= v1_x; vy_q[1] <= v1_y; vz_q[1] <= v1_z;
			vx_q[2] <= v2_x; vy_q[2] <= v2_y; vz_q[2] <= v2_z;
		end
		if (state_q == FE_LOAD) begin
			neg_q <= num[27];
			quo_q <= num_abs[MAG_W-1:0];
			rem_q <= '0;
			den_q <= {sel_x[14:0], 1'b0};
		end
		if (state_q == FE_DIV) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
		if (state_q == FE_FIN) begin
			if (job_q[0])
				pc_q[vk] <= coord;
			else
				pr_q[vk] <= coord;
		end
	end

endmodule

`default_nettype wire

### design/ptr_fifo.sv
// ----------------------------------------------------------------------------
// ptr_fifo
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ptr_pkg::job_t din,
	input  logic          pop,
	output ptr_pkg::job_t head,
	output logic          full,
	output logic          empty
);
	import ptr_pkg::*;

	job_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_PTR_W:0]   cnt_q;

	assign full = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

endmodule

`default_nettype wire

### design/ptr_back.sv
// ----------------------------------------------------------------------------
// ptr_back
// Owns the framebuffer: clears it, reads words and scans triangles with
// incremental edge functions, one pixel per cycle inside each word segment.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_back #(
	parameter int SCREEN_SIZE = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ptr_pkg::job_t     head,
	input  logic              empty,
	output logic              pop,
	output ptr_pkg::bk_stat_t stat
);
	import ptr_pkg::*;

	localparam int WPR = (SCREEN_SIZE + 63) / 64;
	localparam int DEPTH = SCREEN_SIZE * WPR;
	localparam int AW = $clog2(DEPTH);
	localparam int XW = $clog2(SCREEN_SIZE);
	localparam int WW = (WPR > 1) ? $clog2(WPR) : 1;
	localparam int DW = COORD_W + 1;
	localparam int PW = 2 * DW;
	localparam int EW = PW + 4;

	bk_state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic          done_q;
	cmd_kind_t     status_q;
	logic [COUNT_W-1:0] cnt_out_q, count_q;
	logic [63:0]   data_out_q, rdata_q, mask_q;
	job_t          job_q;
	logic [XW-1:0] r0_q, r1_q, c0_q, c1_q, r_q, c_q;
	logic signed [DW-1:0] a_q [3];
	logic signed [DW-1:0] b_q [3];
	logic signed [EW-1:0] erow_q [3];
	logic signed [EW-1:0] ecur_q [3];
	logic signed [PW-1:0] prod_q;
	logic [2:0]    step_q;
	logic [1:0]    mark_q;

	logic [63:0]   mem [DEPTH];
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [63:0]   mem_wdata;

	logic          fin;
	cmd_kind_t     fin_status;
	logic [63:0]   fin_data;

	coord_t rmin, rmax, cmin, cmax;
	logic   any;
	logic   in_tri, seg_end, rd_ok, mark_on;
	logic [1:0] se, sp_e, mk;
	logic [2:0] sp;
	logic signed [DW-1:0] op_a, op_b;
	coord_t mk_r, mk_c;

	function automatic logic [1:0] nxt(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	function automatic logic [XW-1:0] clip(input coord_t v);
		if (v < 0)
			return '0;
		else if (v > COORD_W'(SCREEN_SIZE - 1))
			return XW'(SCREEN_SIZE - 1);
		else
			return v[XW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] r,
			input logic [WW-1:0] w);
		return AW'(r) * AW'(WPR) + AW'(w);
	endfunction

	always_comb begin
		rmin = job_q.pr[0]; rmax = job_q.pr[0];
		cmin = job_q.pc[0]; cmax = job_q.pc[0];
		for (int k = 1; k < 3; k++) begin
			if (job_q.pr[k] < rmin) rmin = job_q.pr[k];
			if (job_q.pr[k] > rmax) rmax = job_q.pr[k];
			if (job_q.pc[k] < cmin) cmin = job_q.pc[k];
			if (job_q.pc[k] > cmax) cmax = job_q.pc[k];
		end
	end

	assign any = !(rmax < 0 || rmin > COORD_W'(SCREEN_SIZE - 1) ||
		cmax < 0 || cmin > COORD_W'(SCREEN_SIZE - 1));
	assign in_tri = !ecur_q[0][EW-1] && !ecur_q[1][EW-1] && !ecur_q[2][EW-1];
	assign seg_end = (c_q == c1_q) || (6'(c_q) == 6'd63);
	assign rd_ok = (int'(job_q.row) < SCREEN_SIZE) && (int'(job_q.word) < WPR);
	assign mk = mark_q;
	assign mk_r = job_q.pr[mk];
	assign mk_c = job_q.pc[mk];
	assign mark_on = (mk_r >= 0) && (mk_r <= COORD_W'(SCREEN_SIZE - 1)) &&
		(mk_c >= 0) && (mk_c <= COORD_W'(SCREEN_SIZE - 1));

	// Setup products: even steps A*(c0 - a.c), odd steps B*(r0 - a.r).
	assign se = step_q[2:1];
	assign sp = step_q - 3'd1;
	assign sp_e = sp[2:1];
	assign op_a = step_q[0] ? b_q[se] : a_q[se];
	assign op_b = step_q[0] ?
		DW'($signed({1'b0, r0_q})) - DW'(job_q.pr[se]) :
		DW'($signed({1'b0, c0_q})) - DW'(job_q.pc[se]);

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = '0;
		mem_raddr = '0;
		mem_wdata = '0;
		fin = 1'b0;
		fin_status = job_q.kind;
		fin_data = '0;
		unique case (state_q)
			BK_INIT, BK_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = BK_IDLE;
					fin = (state_q == BK_CLEAR);
				end
			end
			BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (head.kind)
						CMD_DRAW: state_d = BK_BOX;
						CMD_READ: state_d = BK_READ;
						CMD_CLEAR: state_d = BK_CLEAR;
						CMD_REJECT: begin
							fin = 1'b1;
							fin_status = CMD_REJECT;
						end
					endcase
				end
			end
			BK_READ: begin
				if (rd_ok) begin
					mem_re = 1'b1;
					mem_raddr = addr_of(XW'(job_q.row), WW'(job_q.word));
					state_d = BK_READ_WAIT;
				end else begin
					fin = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_READ_WAIT: begin
				fin = 1'b1;
				fin_data = rdata_q;
				state_d = BK_IDLE;
			end
			BK_BOX: state_d = any ? BK_SETUP : BK_MARK_RD;
			BK_SETUP: begin
				if (step_q == 3'd6)
					state_d = BK_ROW;
			end
			BK_ROW: state_d = BK_RD;
			BK_RD: begin
				mem_re = 1'b1;
				mem_raddr = addr_of(r_q, WW'(c_q >> 6));
				state_d = BK_PIX;
			end
			BK_PIX: begin
				if (seg_end)
					state_d = BK_WR;
			end
			BK_WR: begin
				mem_we = 1'b1;
				mem_waddr = addr_of(r_q, WW'(c_q >> 6));
				mem_wdata = rdata_q | mask_q;
				if (c_q != c1_q)
					state_d = BK_RD;
				else if (r_q == r1_q)
					state_d = BK_MARK_RD;
				else
					state_d = BK_ROW;
			end
			BK_MARK_RD: begin
				if (mark_on) begin
					mem_re = 1'b1;
					mem_raddr = addr_of(mk_r[XW-1:0], WW'(mk_c[XW-1:0] >> 6));
					state_d = BK_MARK_WR;
				end else if (mark_q == 2'd2) begin
					fin = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_MARK_WR: begin
				mem_we = 1'b1;
				mem_waddr = addr_of(mk_r[XW-1:0], WW'(mk_c[XW-1:0] >> 6));
				mem_wdata = rdata_q | (64'd1 << mk_c[5:0]);
				if (mark_q == 2'd2) begin
					fin = 1'b1;
					state_d = BK_IDLE;
				end else begin
					state_d = BK_MARK_RD;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= fin;
			if (state_q == BK_INIT || state_q == BK_CLEAR)
				clr_q <= clr_q + 1'b1;
			else
				clr_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			status_q <= fin_status;
			cnt_out_q <= (fin_status == CMD_DRAW) ? count_q : '0;
			data_out_q <= fin_data;
		end
		unique case (state_q)
			BK_IDLE: begin
				if (pop)
					job_q <= head;
				count_q <= '0;
			end
			BK_BOX: begin
				r0_q <= clip(rmin);
				r1_q <= clip(rmax);
				c0_q <= clip(cmin);
				c1_q <= clip(cmax);
				r_q <= clip(rmin);
				step_q <= '0;
				mark_q <= '0;
				for (int i = 0; i < 3; i++) begin
					a_q[i] <= DW'(job_q.pr[nxt(2'(i))]) - DW'(job_q.pr[i]);
					b_q[i] <= DW'(job_q.pc[nxt(2'(i))]) - DW'(job_q.pc[i]);
				end
			end
			BK_SETUP: begin
				step_q <= step_q + 3'd1;
				if (step_q != 3'd6)
					prod_q <= op_a * op_b;
				if (step_q != 3'd0) begin
					if (!sp[0])
						erow_q[sp_e] <= EW'(prod_q);
					else
						erow_q[sp_e] <= erow_q[sp_e] - EW'(prod_q);
				end
			end
			BK_ROW: begin
				ecur_q <= erow_q;
				c_q <= c0_q;
			end
			BK_RD: mask_q <= '0;
			BK_PIX: begin
				if (in_tri) begin
					mask_q[6'(c_q)] <= 1'b1;
					count_q <= count_q + 1'b1;
				end
				if (!seg_end) begin
					c_q <= c_q + 1'b1;
					for (int i = 0; i < 3; i++)
						ecur_q[i] <= ecur_q[i] + EW'(a_q[i]);
				end
			end
			BK_WR: begin
				if (c_q != c1_q) begin
					c_q <= c_q + 1'b1;
					for (int i = 0; i < 3; i++)
						ecur_q[i] <= ecur_q[i] + EW'(a_q[i]);
				end else if (r_q != r1_q) begin
					r_q <= r_q + 1'b1;
					for (int i = 0; i < 3; i++)
						erow_q[i] <= erow_q[i] - EW'(b_q[i]);
				end
			end
			BK_MARK_RD: begin
				if (!mark_on && mark_q != 2'd2)
					mark_q <= mark_q + 2'd1;
			end
			BK_MARK_WR: begin
				if (mark_q != 2'd2)
					mark_q <= mark_q + 2'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_raddr];
	end

	assign stat.init = (state_q == BK_INIT);
	assign stat.done = done_q;
	assign stat.status = status_q;
	assign stat.count = cnt_out_q;
	assign stat.data = data_out_q;

endmodule

`default_nettype wire

### design/perspective_triangle_rasterizer_core.sv
// ----------------------------------------------------------------------------
// perspective_triangle_rasterizer_core
// Perspective triangle rasterizer with a 1-bit framebuffer.
// ----------------------------------------------------------------------------
// Usage:
// A command is transferred at a rising edge where start is high and busy is
// low. func selects draw, read or clear; the vertex ports carry a triangle in
// signed Q8.8 and read_row/read_word select a 64-pixel framebuffer word.
// Every command yields exactly one result, shown for one cycle with done high.
// The receiver cannot stall, so results are never held back.
// A clear sweeps the framebuffer memory at one word per cycle, through all
// SCREEN_SIZE * ceil(SCREEN_SIZE/64) words (4096 by default). A draw first
// projects its six coordinates through the front end's bit-serial divider,
// then does the box and edge setup, then steps through the rows and pixels
// of the clipped bounding box, reading and writing the memory port once per
// 64-pixel word segment, and finally sets the vertex marks. Projection of
// the next draw overlaps the scan of the current one. After reset the same
// sweep clears the framebuffer; busy stays high until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_triangle_rasterizer_core #(
	parameter int SCREEN_SIZE = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [15:0] v0_x,
	input  logic signed [15:0] v0_y,
	input  logic signed [15:0] v0_z,
	input  logic signed [15:0] v1_x,
	input  logic signed [15:0] v1_y,
	input  logic signed [15:0] v1_z,
	input  logic signed [15:0] v2_x,
	input  logic signed [15:0] v2_y,
	input  logic signed [15:0] v2_z,
	input  logic [8:0]         read_row,
	input  logic [2:0]         read_word,
	output logic               done,
	output logic [1:0]         status,
	output logic [18:0]        covered_count,
	output logic [63:0]        read_data
);
	import ptr_pkg::*;

	logic     accept;
	logic     fe_busy;
	logic     fe_push;
	job_t     fe_job;
	job_t     q_head;
	logic     q_full, q_empty, q_pop;
	bk_stat_t bk_stat;

	// New commands are held off while the front end is projecting, while the
	// queue has no room, and during the clearing sweep that follows reset.
	assign busy = fe_busy || q_full || bk_stat.init;
	assign accept = start && !busy;

	ptr_front #(
		.SCREEN_SIZE(SCREEN_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.func      (func),
		.v0_x      (v0_x),
		.v0_y      (v0_y),
		.v0_z      (v0_z),
		.v1_x      (v1_x),
		.v1_y      (v1_y),
		.v1_z      (v1_z),
		.v2_x      (v2_x),
		.v2_y      (v2_y),
		.v2_z      (v2_z),
		.read_row  (read_row),
		.read_word (read_word),
		.fifo_full (q_full),
		.push      (fe_push),
		.job       (fe_job),
		.fe_busy   (fe_busy)
	);

	// The queue keeps commands in order, so a read always sees every earlier
	// draw and clear.
	ptr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.din    (fe_job),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	ptr_back #(
		.SCREEN_SIZE(SCREEN_SIZE)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (q_pop),
		.stat   (bk_stat)
	);

	// Result registers live in the back end; the status code is the job kind.
	assign done = bk_stat.done;
	assign status = bk_stat.status;
	assign covered_count = bk_stat.count;
	assign read_data = bk_stat.data;

`include "perspective_triangle_rasterizer_core_assert.svh"

	`PTR_CHECK(a_no_overflow, clk, arst_n, fe_push, !q_full, "job queue overflow")
	`PTR_CHECK(a_clear_zero, clk, arst_n, done && status == CMD_CLEAR, covered_count == '0 && read_data == '0, "clear result not zero")
	`PTR_CHECK(a_reject_now, clk, arst_n, accept && func == FUNC_DRAW && v0_x <= 16'sd0, fe_push, "rejected draw not queued at once")

endmodule

`default_nettype wire

### sim/perspective_triangle_rasterizer_core_test.sv
// ----------------------------------------------------------------------------
// perspective_triangle_rasterizer_core_test
// Self-checking bench for the perspective triangle rasterizer core: commands
// go in with random gaps, and every result is compared with a framebuffer
// model kept alongside it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module perspective_triangle_rasterizer_core_test;
	import ptr_pkg::*;

	localparam int SCREEN = 512;
	localparam int ROW_WORDS = (SCREEN + 63) / 64;
	localparam int FB_WORDS = SCREEN * ROW_WORDS;
	// The spare func code is decoded as a read.
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	// The limit lies above the scan time of a full-screen draw.
	localparam int IDLE_LIMIT = 1000000;

	typedef struct {
		logic [1:0]         func;
		logic signed [15:0] vx [3];
		logic signed [15:0] vy [3];
		logic signed [15:0] vz [3];
		logic [8:0]         row;
		logic [2:0]         word;
	} raster_cmd_t;

	typedef struct {
		cmd_kind_t   status;
		logic [18:0] count;
		logic [63:0] data;
	} raster_res_t;

	// Scoreboard: keeps its own framebuffer and the queue of pending results.
	class raster_scoreboard;
		logic [63:0] frame [FB_WORDS];
		raster_res_t pending [$];
		int errors;
		int n_draw, n_reject, n_read, n_clear, n_checked;

		function new();
			foreach (frame[i]) frame[i] = '0;
			errors = 0;
		endfunction

		function longint floor_quot(longint num, longint den);
			longint q;
			q = num / den;
			if ((num % den) != 0 && num < 0) q--;
			return q;
		endfunction

		function void plot(longint r, longint c);
			if (r < 0 || r >= SCREEN || c < 0 || c >= SCREEN) return;
			frame[r * ROW_WORDS + (c >> 6)][c & 63] = 1'b1;
		endfunction

		function longint side(longint ar, longint ac, longint br, longint bc,
				longint r, longint c);
			return (br - ar) * (c - ac) - (bc - ac) * (r - ar);
		endfunction

		function longint clamp(longint v);
			if (v < 0) return 0;
			if (v > SCREEN - 1) return SCREEN - 1;
			return v;
		endfunction

		// Note an accepted command and queue the result it must produce.
		function void note_command(raster_cmd_t cmd);
			raster_res_t res;
			longint pr [3];
			longint pc [3];
			longint x, rmin, rmax, cmin, cmax, cnt;
			res.status = CMD_DRAW;
			res.count = '0;
			res.data = '0;
			if (cmd.func == FUNC_CLEAR) begin
				foreach (frame[i]) frame[i] = '0;
				res.status = CMD_CLEAR;
				n_clear++;
				pending.push_back(res);
				return;
			end
			if (cmd.func != FUNC_DRAW) begin
				if (cmd.row < SCREEN && cmd.word < ROW_WORDS)
					res.data = frame[cmd.row * ROW_WORDS + cmd.word];
				res.status = CMD_READ;
				n_read++;
				pending.push_back(res);
				return;
			end
			for (int k = 0; k < 3; k++) begin
				x = cmd.vx[k];
				if (x <= 0) begin
					res.status = CMD_REJECT;
					n_reject++;
					pending.push_back(res);
					return;
				end
				pr[k] = floor_quot((longint'(cmd.vy[k]) + x) * SCREEN, 2 * x);
				pc[k] = floor_quot((longint'(cmd.vz[k]) + x) * SCREEN, 2 * x);
			end
			rmin = pr[0]; rmax = pr[0]; cmin = pc[0]; cmax = pc[0];
			for (int k = 1; k < 3; k++) begin
				if (pr[k] < rmin) rmin = pr[k];
				if (pr[k] > rmax) rmax = pr[k];
				if (pc[k] < cmin) cmin = pc[k];
				if (pc[k] > cmax) cmax = pc[k];
			end
			cnt = 0;
			if (!(rmax < 0 || rmin > SCREEN - 1 || cmax < 0 || cmin > SCREEN - 1)) begin
				for (longint r = clamp(rmin); r <= clamp(rmax); r++)
					for (longint c = clamp(cmin); c <= clamp(cmax); c++)
						if (side(pr[0], pc[0], pr[1], pc[1], r, c) >= 0 &&
								side(pr[1], pc[1], pr[2], pc[2], r, c) >= 0 &&
								side(pr[2], pc[2], pr[0], pc[0], r, c) >= 0) begin
							plot(r, c);
							cnt++;
						end
			end
			for (int k = 0; k < 3; k++) plot(pr[k], pc[k]);
			res.count = cnt[18:0];
			n_draw++;
			pending.push_back(res);
		endfunction

		// Compare one result with the oldest pending one.
		function void check_result(logic [1:0] status, logic [18:0] count,
				logic [63:0] data);
			raster_res_t exp_res;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d count=%0d data=%h",
					$time, status, count, data);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			n_checked++;
			if (status !== exp_res.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
				errors++;
			end
			if (count !== exp_res.count) begin
				$display("%0t: covered_count expected %0d actual %0d",
					$time, exp_res.count, count);
				errors++;
			end
			if (data !== exp_res.data) begin
				$display("%0t: read_data expected %h actual %h", $time, exp_res.data, data);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         func;
	logic signed [15:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
	logic [8:0]         read_row;
	logic [2:0]         read_word;
	logic               done;
	logic [1:0]         status;
	logic [18:0]        covered_count;
	logic [63:0]        read_data;

	perspective_triangle_rasterizer_core #(.SCREEN_SIZE(SCREEN)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
		.v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
		.v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
		.read_row(read_row), .read_word(read_word),
		.done(done), .status(status), .covered_count(covered_count),
		.read_data(read_data)
	);

	raster_scoreboard scoreboard = new();
	raster_cmd_t cur_cmd;
	int idle_cycles = 0;
	// Center of the last small triangle, so that reads land on drawn pixels.
	int focus_row = 0;
	int focus_col = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Sampling happens at the rising edge, before the design's registers
	// update, so the values seen are the ones the edge transfers.
	always @(posedge clk) begin
		if (arst_n && start && !busy) scoreboard.note_command(cur_cmd);
		if (arst_n && done) scoreboard.check_result(status, covered_count, read_data);
	end

	// Watchdog: counts cycles in which neither a command nor a result moves.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Drive one command at the falling edge and hold it until it transfers.
	task automatic send_cmd(raster_cmd_t cmd);
		@(negedge clk);
		cur_cmd = cmd;
		start <= 1'b1;
		func <= cmd.func;
		v0_x <= cmd.vx[0]; v0_y <= cmd.vy[0]; v0_z <= cmd.vz[0];
		v1_x <= cmd.vx[1]; v1_y <= cmd.vy[1]; v1_z <= cmd.vz[1];
		v2_x <= cmd.vx[2]; v2_y <= cmd.vy[2]; v2_z <= cmd.vz[2];
		read_row <= cmd.row;
		read_word <= cmd.word;
		do @(posedge clk); while (busy);
	endtask

	// Random pause after a transfer: mostly none or short, sometimes long.
	task automatic idle_gap();
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) gap = 0;
		else if (pick < 92) gap = $urandom_range(1, 4);
		else gap = $urandom_range(20, 150);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic raster_cmd_t blank_cmd(logic [1:0] f);
		raster_cmd_t cmd;
		cmd.func = f;
		for (int k = 0; k < 3; k++) begin
			cmd.vx[k] = '0; cmd.vy[k] = '0; cmd.vz[k] = '0;
		end
		cmd.row = '0;
		cmd.word = '0;
		return cmd;
	endfunction

	// Pick a lateral coordinate so that the vertex projects near a pixel.
	function automatic logic signed [15:0] aim(int target, int depth);
		longint v;
		v = (longint'(target) * depth) / (SCREEN / 2) - depth;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// A small triangle with random depths and either winding.
	function automatic raster_cmd_t small_triangle();
		raster_cmd_t cmd;
		int depth;
		int spread;
		cmd = blank_cmd(FUNC_DRAW);
		focus_row = $urandom_range(0, SCREEN + 40) - 20;
		focus_col = $urandom_range(0, SCREEN + 40) - 20;
		spread = $urandom_range(1, 14);
		for (int k = 0; k < 3; k++) begin
			depth = $urandom_range(64, 16000);
			cmd.vx[k] = 16'(depth);
			cmd.vy[k] = aim(focus_row + $urandom_range(0, 2 * spread) - spread, depth);
			cmd.vz[k] = aim(focus_col + $urandom_range(0, 2 * spread) - spread, depth);
		end
		return cmd;
	endfunction

	function automatic raster_cmd_t read_cmd(bit near_focus);
		raster_cmd_t cmd;
		cmd = blank_cmd(($urandom_range(0, 9) == 0) ? FUNC_SPARE : FUNC_READ);
		if (near_focus && focus_row >= 0 && focus_row < SCREEN && focus_col >= 0
				&& focus_col < SCREEN) begin
			cmd.row = 9'(focus_row);
			cmd.word = 3'(focus_col / 64);
		end else begin
			cmd.row = 9'($urandom);
			cmd.word = 3'($urandom);
		end
		return cmd;
	endfunction

	// Noise draw with one vertex forced behind the eye, so it is rejected.
	function automatic raster_cmd_t rejected_draw();
		raster_cmd_t cmd;
		int bad;
		cmd = blank_cmd(FUNC_DRAW);
		for (int k = 0; k < 3; k++) begin
			cmd.vx[k] = 16'($urandom); cmd.vy[k] = 16'($urandom);
			cmd.vz[k] = 16'($urandom);
		end
		bad = $urandom_range(0, 2);
		cmd.vx[bad] = -$signed({1'b0, 15'($urandom)});
		cmd.row = 9'($urandom);
		cmd.word = 3'($urandom);
		return cmd;
	endfunction

	function automatic raster_cmd_t flat_draw(int r0, int c0, int r1, int c1,
			int r2, int c2);
		raster_cmd_t cmd;
		cmd = blank_cmd(FUNC_DRAW);
		// Depth 256 projects lateral l to pixel l + 256.
		for (int k = 0; k < 3; k++) cmd.vx[k] = 16'sd256;
		cmd.vy[0] = 16'(r0 - 256); cmd.vz[0] = 16'(c0 - 256);
		cmd.vy[1] = 16'(r1 - 256); cmd.vz[1] = 16'(c1 - 256);
		cmd.vy[2] = 16'(r2 - 256); cmd.vz[2] = 16'(c2 - 256);
		return cmd;
	endfunction

	initial begin
		raster_cmd_t cmd;
		int pick;
		int wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_DRAW;
		{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} = '0;
		read_row = '0;
		read_word = '0;
		cur_cmd = blank_cmd(FUNC_DRAW);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: reads of a fresh framebuffer, the spare code, both
		// windings, rejects at each vertex and the coordinate extremes.
		cmd = blank_cmd(FUNC_READ); cmd.row = 9'd511; cmd.word = 3'd7; send_cmd(cmd);
		cmd = blank_cmd(FUNC_SPARE); cmd.row = 9'd0; send_cmd(cmd);
		cmd = flat_draw(10, 10, 10, 40, 40, 10); send_cmd(cmd);
		cmd = flat_draw(10, 10, 40, 10, 10, 40); send_cmd(cmd);
		cmd = blank_cmd(FUNC_READ); cmd.row = 9'd20; send_cmd(cmd);
		cmd = blank_cmd(FUNC_READ); cmd.row = 9'd10; send_cmd(cmd);
		for (int k = 0; k < 3; k++) begin
			cmd = flat_draw(1, 1, 5, 5, 1, 9);
			cmd.vx[k] = (k == 1) ? 16'sh8000 : 16'sd0;
			send_cmd(cmd);
		end
		// Tiny depth and far vertices: off screen, box entirely clipped away.
		cmd = blank_cmd(FUNC_DRAW);
		for (int k = 0; k < 3; k++) begin
			cmd.vx[k] = 16'sd1; cmd.vy[k] = 16'sh7fff; cmd.vz[k] = -16'sh8000;
		end
		send_cmd(cmd);
		// Greatest depth with extreme laterals: vertices land just outside the screen edges.
		cmd = blank_cmd(FUNC_DRAW);
		for (int k = 0; k < 3; k++) begin
			cmd.vx[k] = 16'sh7fff; cmd.vy[k] = 16'sh7fff; cmd.vz[k] = -16'sh8000;
		end
		cmd.vy[1] = -16'sh8000; cmd.vz[2] = 16'sh7fff;
		send_cmd(cmd);
		// Screen-sized triangles, one with vertices beyond the edges and one at the corners.
		cmd = flat_draw(-300, -300, -300, 900, 900, -300); send_cmd(cmd);
		cmd = blank_cmd(FUNC_READ); cmd.row = 9'd300; cmd.word = 3'd2; send_cmd(cmd);
		cmd = blank_cmd(FUNC_CLEAR); send_cmd(cmd);
		cmd = blank_cmd(FUNC_READ); cmd.row = 9'd300; cmd.word = 3'd2; send_cmd(cmd);
		cmd = flat_draw(511, 511, 0, 511, 511, 0); send_cmd(cmd);
		cmd = blank_cmd(FUNC_READ); cmd.row = 9'd511; cmd.word = 3'd7; send_cmd(cmd);
		cmd = blank_cmd(FUNC_CLEAR); send_cmd(cmd);

		// Random part: mostly small triangles with reads that look at them.
		for (int i = 0; i < 580; i++) begin
			pick = $urandom_range(0, 199);
			if (pick < 3) cmd = blank_cmd(FUNC_CLEAR);
			else if (pick < 20) cmd = rejected_draw();
			else if (pick < 45) cmd = read_cmd(1'b1);
			else if (pick < 65) cmd = read_cmd(1'b0);
			else cmd = small_triangle();
			send_cmd(cmd);
			if ($urandom_range(0, 3) != 0) idle_gap();
		end
		@(negedge clk);
		start <= 1'b0;

		wait_cycles = 0;
		while (scoreboard.pending.size() != 0 && wait_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (50) @(posedge clk);

		$display("Covered %0d draws, %0d rejected draws, %0d reads and %0d clears;",
			scoreboard.n_draw, scoreboard.n_reject, scoreboard.n_read, scoreboard.n_clear);
		$display("%0d results compared, %0d still outstanding.",
			scoreboard.n_checked, scoreboard.pending.size());
		if (scoreboard.errors == 0 && scoreboard.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+design
design/ptr_pkg.sv
design/ptr_front.sv
design/ptr_fifo.sv
design/ptr_back.sv
design/perspective_triangle_rasterizer_core.sv
sim/perspective_triangle_rasterizer_core_test.sv
